FILE: rtl/pom_pkg.sv
// ----------------------------------------------------------------------------
// pom_pkg: shared types and constants for the perturb-and-observe tracker
// Holds the request payload types, the configuration view and the register
// indexes used by every module of the block.
// ----------------------------------------------------------------------------
package pom_pkg;

    // Converter and PWM constants.
    localparam int ADC_BITS    = 10;
    localparam int DUTY_BITS   = 7;
    localparam int POWER_BITS  = 2 * ADC_BITS;
    localparam int PWM_PERIOD  = 100;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    // Largest duty the 7-bit field can hold, and the effective upper cap.
    localparam int DUTY_FIELD_MAX = (1 << DUTY_BITS) - 1;
    localparam int DUTY_CAP =
        (PWM_PERIOD < DUTY_FIELD_MAX) ? PWM_PERIOD : DUTY_FIELD_MAX;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BATT_FULL    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_INITIAL = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DUTY_BITS-1:0] DUTY_MIN_RESET     = 7'd3;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX_RESET     = 7'd97;
    localparam logic [ADC_BITS-1:0]  BATT_FULL_RESET    = 10'd1023;
    localparam logic [DUTY_BITS-1:0] DUTY_INITIAL_RESET = 7'd0;

    // One input sample.
    typedef struct packed {
        logic [ADC_BITS-1:0] voltage_code;
        logic [ADC_BITS-1:0] current_code;
        logic [ADC_BITS-1:0] battery_code;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [DUTY_BITS-1:0]  duty;
        logic [POWER_BITS-1:0] power_code;
        logic                  battery_full;
    } t_out_item;

    // Configuration as seen by the tracking logic.
    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_min;
        logic [DUTY_BITS-1:0] duty_max;
        logic [ADC_BITS-1:0]  battery_full_code;
    } t_cfg;

endpackage

FILE: rtl/pom_cfg_regs.sv
// ----------------------------------------------------------------------------
// pom_cfg_regs: configuration registers
// Decodes the plain write port into the limit and threshold registers.
// ----------------------------------------------------------------------------
module pom_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pom_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pom_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pom_pkg::t_cfg                     o_cfg
);

    pom_pkg::t_cfg r_cfg;
    pom_pkg::t_cfg n_cfg;

    // Write decode. The initial duty register only matters at reset, and at
    // reset it holds its own reset value, so a write to it changes nothing
    // that can be observed and is not stored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                pom_pkg::REG_DUTY_MIN: begin
                    n_cfg.duty_min = i_cfg_data[pom_pkg::DUTY_BITS-1:0];
                end
                pom_pkg::REG_DUTY_MAX: begin
                    n_cfg.duty_max = i_cfg_data[pom_pkg::DUTY_BITS-1:0];
                end
                pom_pkg::REG_BATT_FULL: begin
                    n_cfg.battery_full_code = i_cfg_data[pom_pkg::ADC_BITS-1:0];
                end
                pom_pkg::REG_DUTY_INITIAL: begin
                    n_cfg = r_cfg;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_min          <= pom_pkg::DUTY_MIN_RESET;
            r_cfg.duty_max          <= pom_pkg::DUTY_MAX_RESET;
            r_cfg.battery_full_code <= pom_pkg::BATT_FULL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/pom_in_reg.sv
// ----------------------------------------------------------------------------
// pom_in_reg: input register stage
// Captures one sample request and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module pom_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pom_pkg::t_in_item i_in_data,
    output logic              o_s1_valid,
    input  logic              i_s1_take,
    output pom_pkg::t_in_item o_s1_data
);

    logic              r_valid;
    pom_pkg::t_in_item r_data;

    // The stage can load when it is empty or its content leaves this cycle.
    assign o_in_ready = !r_valid || i_s1_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1_data  = r_data;

endmodule

FILE: rtl/pom_tracker.sv
// ----------------------------------------------------------------------------
// pom_tracker: power calculation, duty step and result register
// Forms panel power, compares with the previous sample, steps and clamps the
// duty, and registers the result request.
// ----------------------------------------------------------------------------
module pom_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pom_pkg::t_cfg      i_cfg,
    input  logic               i_s1_valid,
    output logic               o_s1_take,
    input  pom_pkg::t_in_item  i_s1_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pom_pkg::t_out_item o_out_data
);

    localparam int STEP_W = pom_pkg::DUTY_BITS + 2;

    logic                              r_out_valid;
    pom_pkg::t_out_item                r_out_data;
    logic [pom_pkg::POWER_BITS-1:0]    r_prev_power;
    logic [pom_pkg::ADC_BITS-1:0]      r_prev_voltage;
    logic [pom_pkg::DUTY_BITS-1:0]     r_duty;

    logic [pom_pkg::POWER_BITS-1:0]    n_power;
    logic                              n_full;
    logic                              power_up;
    logic                              volt_up;
    logic signed [STEP_W-1:0]          step_d;
    logic signed [STEP_W-1:0]          clamp_d;
    logic [pom_pkg::DUTY_BITS-1:0]     n_duty;

    // The sample moves on when the result slot is free or being emptied.
    assign o_s1_take = i_s1_valid && (!r_out_valid || i_out_ready);

    // Power, battery check and direction of the last move.
    always_comb begin
        n_power  = pom_pkg::POWER_BITS'(i_s1_data.voltage_code * i_s1_data.current_code);
        n_full   = i_s1_data.battery_code >= i_cfg.battery_full_code;
        power_up = n_power > r_prev_power;
        volt_up  = i_s1_data.voltage_code > r_prev_voltage;
    end

    // Signed step by one, then the limit clamps in order: max, min, period; a full battery gives zero.
    always_comb begin
        if (power_up == volt_up) begin
            step_d = $signed({2'b00, r_duty}) - STEP_W'(1);
        end else begin
            step_d = $signed({2'b00, r_duty}) + STEP_W'(1);
        end
        clamp_d = step_d;
        if (clamp_d > $signed({2'b00, i_cfg.duty_max})) begin
            clamp_d = $signed({2'b00, i_cfg.duty_max});
        end
        if (clamp_d < $signed({2'b00, i_cfg.duty_min})) begin
            clamp_d = $signed({2'b00, i_cfg.duty_min});
        end
        if (clamp_d > $signed(STEP_W'(pom_pkg::DUTY_CAP))) begin
            clamp_d = $signed(STEP_W'(pom_pkg::DUTY_CAP));
        end
        if (clamp_d < $signed(STEP_W'(0))) begin
            clamp_d = '0;
        end
        if (n_full) begin
            n_duty = '0;
        end else begin
            n_duty = clamp_d[pom_pkg::DUTY_BITS-1:0];
        end
    end

    // Tracker state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_prev_power   <= '0;
            r_prev_voltage <= '0;
            r_duty         <= pom_pkg::DUTY_INITIAL_RESET;
        end else begin
            if (o_s1_take) begin
                r_out_valid    <= 1'b1;
                r_prev_power   <= n_power;
                r_prev_voltage <= i_s1_data.voltage_code;
                r_duty         <= n_duty;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_out_data.duty         <= n_duty;
            r_out_data.power_code   <= n_power;
            r_out_data.battery_full <= n_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/perturb_observe_mppt.sv
// ----------------------------------------------------------------------------
// perturb_observe_mppt: perturb-and-observe maximum power point tracker
// Takes voltage, current and battery samples and returns the next PWM duty.
// ----------------------------------------------------------------------------
// The block accepts one sample every clock cycle while results are taken,
// and returns one result per sample: the sample lands in an input register,
// and once the result slot is free the result register is written with the
// duty and previous-sample registers. The loop through those registers, one
// 10 by 10 bit multiply and a 20-bit compare, sets the single-cycle rate.
// Configuration writes take effect at the next edge and should be made while
// no sample is in flight. After reset the duty starts at zero.
module perturb_observe_mppt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pom_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pom_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pom_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pom_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pom_pkg::t_cfg     cfg;
    logic              s1_valid;
    logic              s1_take;
    pom_pkg::t_in_item s1_data;

    // Configuration registers.
    pom_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register stage.
    pom_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_s1_valid (s1_valid),
        .i_s1_take  (s1_take),
        .o_s1_data  (s1_data)
    );

    // Tracking logic and result register.
    pom_tracker u_trk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_s1_valid  (s1_valid),
        .o_s1_take   (s1_take),
        .i_s1_data   (s1_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/pom_checker.sv
// ----------------------------------------------------------------------------
// pom_checker: port-level checks for the tracker
// Watches the top-level ports and flags results that break the duty rules.
// ----------------------------------------------------------------------------
module pom_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pom_pkg::t_out_item o_out_data
);

    // A stalled result request stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A full battery always comes with zero duty.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.battery_full |-> o_out_data.duty == '0)
        else $error("battery full but duty not zero");

    // Duty never exceeds the PWM period.
    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.duty <= pom_pkg::DUTY_CAP)
        else $error("duty above PWM period");

    // Reset leaves no result offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

endmodule

bind perturb_observe_mppt pom_checker u_pom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/duty_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty_scoreboard_pkg: expected-result store for the tracker testbench
// Predicts the duty, power and battery-full flag of every accepted request and
// compares each returned result against the oldest prediction in order.
// ----------------------------------------------------------------------------
package duty_scoreboard_pkg;

    import pom_pkg::*;

    class duty_scoreboard;

        // Predictions not yet matched by a returned result, oldest first.
        t_out_item expected_q[$];

        // Shadow copy of the configuration registers.
        logic [DUTY_BITS-1:0]  duty_min;
        logic [DUTY_BITS-1:0]  duty_max;
        logic [DUTY_BITS-1:0]  duty_initial;
        logic [ADC_BITS-1:0]   full_code;

        // Tracker state: duty register and the previous sample.
        logic [DUTY_BITS-1:0]  duty_now;
        logic [ADC_BITS-1:0]   last_voltage;
        logic [POWER_BITS-1:0] last_power;

        int mismatches;
        int checked;
        int full_seen;
        int duty_lo;
        int duty_hi;

        function new();
            duty_min     = DUTY_MIN_RESET;
            duty_max     = DUTY_MAX_RESET;
            duty_initial = DUTY_INITIAL_RESET;
            full_code    = BATT_FULL_RESET;
            duty_now     = duty_initial;
            last_voltage = '0;
            last_power   = '0;
            mismatches   = 0;
            checked      = 0;
            full_seen    = 0;
            duty_lo      = DUTY_CAP;
            duty_hi      = 0;
        endfunction

        // The duty_initial register only matters at reset, so it is held but
        // never folded back into the duty register here.
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DUTY_MIN:     duty_min     = val[DUTY_BITS-1:0];
                REG_DUTY_MAX:     duty_max     = val[DUTY_BITS-1:0];
                REG_BATT_FULL:    full_code    = val[ADC_BITS-1:0];
                REG_DUTY_INITIAL: duty_initial = val[DUTY_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Work out the next duty for an accepted sample and queue the result.
        function void note_sample(t_in_item s);
            logic [POWER_BITS-1:0] pwr;
            int                    d;
            int                    lo;
            int                    hi;
            t_out_item             want;
            pwr = s.voltage_code * s.current_code;
            want.battery_full = 1'b0;
            if (s.battery_code >= full_code) begin
                want.battery_full = 1'b1;
                duty_now = '0;
            end else begin
                d  = duty_now;
                lo = duty_min;
                hi = duty_max;
                // Power and voltage moving the same way (or both flat) means
                // the operating point is past the peak: back off.
                if ((pwr > last_power) == (s.voltage_code > last_voltage)) begin
                    d = d - 1;
                end else begin
                    d = d + 1;
                end
                // Upper limit first, so a crossed pair leaves the lower limit in force.
                if (d > hi) d = hi;
                if (d < lo) d = lo;
                if (d > PWM_PERIOD) d = PWM_PERIOD;
                if (d > DUTY_FIELD_MAX) d = DUTY_FIELD_MAX;
                if (d < 0) d = 0;
                duty_now = d[DUTY_BITS-1:0];
            end
            last_power      = pwr;
            last_voltage    = s.voltage_code;
            want.duty       = duty_now;
            want.power_code = pwr;
            expected_q.push_back(want);
        endfunction

        // Compare one returned result with the oldest prediction.
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no request outstanding: duty %0d power %0d full %0b",
                             got.duty, got.power_code, got.battery_full);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.battery_full === 1'b1) full_seen++;
            if (got.duty < duty_lo) duty_lo = got.duty;
            if (got.duty > duty_hi) duty_hi = got.duty;
            if (got.duty !== want.duty || got.power_code !== want.power_code ||
                got.battery_full !== want.battery_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: duty %0d/%0d power %0d/%0d full %0b/%0b (exp/got)",
                             checked, want.duty, got.duty, want.power_code, got.power_code,
                             want.battery_full, got.battery_full);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the perturb-and-observe tracker
// Drives directed and random sample requests through several configuration
// settings with random gaps and back-pressure, and checks every result.
// ----------------------------------------------------------------------------
module testbench;

    import pom_pkg::*;
    import duty_scoreboard_pkg::*;

    localparam int ITEMS_PER_PHASE = 244;
    localparam int PHASES          = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 300000;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_item               i_in_data   = '0;
    logic                   i_out_ready = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_out_item              o_out_data;

    duty_scoreboard sb;

    // Idle pattern of each side: a style held for a run of requests.
    int send_style = 0;
    int send_left  = 0;
    int recv_style = 0;
    int recv_left  = 0;

    // Sample generator memory: the last request sent and the walk direction.
    int sent_voltage = 0;
    int sent_power   = 0;
    int full_now     = BATT_FULL_RESET;
    bit walk_up      = 1'b0;
    int walk_left    = 0;

    bit long_hold_req = 1'b0;
    int cycle_count   = 0;

    perturb_observe_mppt DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Number of idle cycles before the next request; some runs have none.
    function automatic int draw_wait(inout int style, inout int left);
        if (left == 0) begin
            style = $urandom_range(0, 2);
            left  = $urandom_range(10, 60);
        end
        left--;
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic t_in_item sample_of(int v, int c, int b);
        t_in_item s;
        s.voltage_code = v[ADC_BITS-1:0];
        s.current_code = c[ADC_BITS-1:0];
        s.battery_code = b[ADC_BITS-1:0];
        return s;
    endfunction

    // A sample that pushes the duty in the chosen walk direction, with the
    // battery mostly below the full threshold and often right at its edge.
    function automatic t_in_item walk_sample();
        int v;
        int c;
        int b;
        int bound;
        int r;
        bit volt_up;
        bit want_rise;
        if (walk_left == 0) begin
            walk_up   = $urandom_range(0, 1);
            walk_left = $urandom_range(5, 120);
        end
        walk_left--;
        v         = $urandom_range(0, 1023);
        volt_up   = (v > sent_voltage);
        want_rise = walk_up ? !volt_up : volt_up;
        bound     = (v == 0) ? 1023 : sent_power / v;
        if (bound > 1023) bound = 1023;
        if (!want_rise) begin
            c = $urandom_range(0, bound);
        end else if (v != 0 && bound < 1023) begin
            c = $urandom_range(bound + 1, 1023);
        end else begin
            c = $urandom_range(0, 1023);
        end
        r = $urandom_range(0, 9);
        if (r < 7 && full_now > 0) begin
            b = $urandom_range(0, full_now - 1);
        end else if (r == 7) begin
            b = full_now;
        end else if (r == 8) begin
            b = (full_now == 0) ? 0 : full_now - 1;
        end else begin
            b = $urandom_range(0, 1023);
        end
        return sample_of(v, c, b);
    endfunction

    // Offer one sample request and hold it until the block takes it.
    task automatic send_sample(input t_in_item s);
        int gap;
        gap = draw_wait(send_style, send_left);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_sample(s);
        sent_voltage = s.voltage_code;
        sent_power   = int'(s.voltage_code) * int'(s.current_code);
    endtask

    // One register write; the caller lowers the write enable after a batch.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.write_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    // Configuration for each phase: wide, narrow, crossed, above the PWM
    // period, always full, pinned at the top, then a random setting.
    task automatic apply_settings(input int ph);
        int dmin;
        int dmax;
        int dfull;
        int dinit;
        case (ph)
            1:       begin dmin = 0;   dmax = 100; dfull = 1023; dinit = 100; end
            2:       begin dmin = 40;  dmax = 45;  dfull = 700;  dinit = 5;   end
            3:       begin dmin = 60;  dmax = 20;  dfull = 512;  dinit = 0;   end
            4:       begin dmin = 127; dmax = 0;   dfull = 900;  dinit = 50;  end
            5:       begin dmin = 0;   dmax = 0;   dfull = 0;    dinit = 127; end
            6:       begin dmin = 100; dmax = 100; dfull = 1023; dinit = 0;   end
            default: begin
                dmin  = $urandom_range(0, 100);
                dmax  = $urandom_range(0, 100);
                dfull = $urandom_range(300, 1023);
                dinit = $urandom_range(0, 100);
            end
        endcase
        write_reg(REG_DUTY_MIN, dmin);
        write_reg(REG_DUTY_MAX, dmax);
        write_reg(REG_BATT_FULL, dfull);
        write_reg(REG_DUTY_INITIAL, dinit);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        full_now = dfull;
    endtask

    // Wait until every outstanding request has produced its result.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = draw_wait(recv_style, recv_left);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result(o_out_data);
        end
    end

    // Main sequence: reset, directed samples, then random phases.
    initial begin
        int ph;
        int n;
        t_in_item s;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flat start, extremes, each direction of power and
        // voltage, battery at and just below the threshold.
        send_sample(sample_of(0, 0, 0));
        send_sample(sample_of(0, 0, 0));
        send_sample(sample_of(1023, 1023, 0));
        send_sample(sample_of(1023, 1023, 0));
        send_sample(sample_of(1023, 1, 0));
        send_sample(sample_of(2, 1023, 0));
        send_sample(sample_of(1000, 1023, 0));
        send_sample(sample_of(682, 341, 341));
        send_sample(sample_of(341, 682, 682));
        send_sample(sample_of(1023, 1023, 1023));
        send_sample(sample_of(5, 5, 1022));
        send_sample(sample_of(1023, 0, 1023));
        send_sample(sample_of(0, 1023, 1022));
        send_sample(sample_of(513, 1022, 0));

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                apply_settings(ph);
            end
            // Back-pressure burst: the result side stops while requests keep coming.
            if (ph == 2) long_hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    s = sample_of($urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023));
                end else begin
                    s = walk_sample();
                end
                send_sample(s);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d results over %0d settings, %0d with the battery full.",
                 sb.checked, PHASES, sb.full_seen);
        $display("Duty ranged %0d..%0d; the result side held off once for %0d cycles.",
                 sb.duty_lo, sb.duty_hi, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
